// ===== design/bdd_pkg.sv =====
// Shared types, constants and helpers of the binary decimal decoder.
`default_nettype none
package bdd_pkg;

  localparam int MAX_PRECISION = 65;
  localparam int RESULT_LIMBS  = 4;
  localparam int ACC_LIMBS     = 4;
  localparam int CMD_DEPTH     = 4;

  localparam logic [29:0] WORD_BASE = 30'd1000000000;

  localparam logic [2:0] DIG_BYTES [10] = '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2,
                                            3'd3, 3'd3, 3'd4, 3'd4, 3'd4};

  localparam logic [29:0] POW10 [9] = '{30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000,
                                        30'd100000, 30'd1000000, 30'd10000000,
                                        30'd100000000};

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_WORD   = 2'd1;
  localparam logic [1:0] ST_HEADER = 2'd2;

  typedef enum logic [1:0] {PH_PREC, PH_SCALE, PH_FIRST, PH_BODY} phase_t;
  typedef enum logic [1:0] {GRP_LEAD, GRP_WORDS, GRP_TRAIL, GRP_DONE} grp_t;
  typedef enum logic [1:0] {CMD_LEAD, CMD_MAC, CMD_BAD} cmd_kind_t;
  typedef enum logic [1:0] {BK_IDLE, BK_MAC, BK_EMIT} back_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] value;
    logic [29:0] mult;
    logic        first;
    logic        last;
    logic        neg;
    logic        err;
    logic [6:0]  precision;
    logic [6:0]  scale;
  } cmd_t;

  // floor(v/9) by reciprocal, exact for every 7-bit value
  function automatic logic [3:0] div9(input logic [6:0] v);
    logic [12:0] p;
    p = 13'(v) * 13'd57;
    return p[12:9];
  endfunction

  function automatic logic [3:0] mod9(input logic [6:0] v);
    logic [6:0] q9;
    logic [6:0] r;
    q9 = 7'({3'b000, div9(v)} * 7'd9);
    r  = v - q9;
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/bdd_cmd_fifo.sv =====
// Short command queue between the byte parser and the arithmetic back end.
`default_nettype none
module bdd_cmd_fifo (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  bdd_pkg::cmd_t push_cmd,
  input  wire           pop,
  output logic          full,
  output logic          head_valid,
  output bdd_pkg::cmd_t head
);
  import bdd_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(CMD_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("command popped from an empty queue");

endmodule
`default_nettype wire

// ===== design/bdd_front.sv =====
// Byte parser: header checks, group sizing, word assembly and command issue.
`default_nettype none
module bdd_front (
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  input  wire  [7:0]    enc_byte,
  input  wire           full,
  output logic          push,
  output bdd_pkg::cmd_t push_cmd
);
  import bdd_pkg::*;

  phase_t      phase, phase_next;
  grp_t        grp, grp_next;
  logic [6:0]  digits_total, digits_total_next;
  logic [6:0]  digits_fraction, digits_fraction_next;
  logic [2:0]  lead_bytes, lead_bytes_next;
  logic [2:0]  trail_bytes, trail_bytes_next;
  logic [3:0]  trail_mod, trail_mod_next;
  logic [3:0]  words_left, words_left_next;
  logic [2:0]  bytes_left, bytes_left_next;
  logic [31:0] word_shift, word_shift_next;
  logic        is_negative, is_negative_next;
  logic        word_error, word_error_next;
  logic        first_grp, first_grp_next;

  logic        accept;
  logic        bad_hdr;
  logic [6:0]  int_digits;
  logic [2:0]  hdr_lead, hdr_trail;
  logic [3:0]  hdr_words;
  logic        first_byte;
  logic [7:0]  b_eff;
  logic        neg_cur;
  logic [2:0]  grp_size;
  logic [31:0] ws_base, ws_new, word_val;
  logic [2:0]  bl_cur, bl_dec;
  logic [3:0]  words_dec;
  logic        err_cur;
  grp_t        grp_after;

  assign accept     = in_valid && !full;
  assign bad_hdr    = (digits_total == '0) || (digits_total > 7'(MAX_PRECISION))
                    || (enc_byte > {1'b0, digits_total});
  assign int_digits = digits_total - enc_byte[6:0];
  assign hdr_lead   = DIG_BYTES[mod9(int_digits)];
  assign hdr_trail  = DIG_BYTES[mod9(enc_byte[6:0])];
  assign hdr_words  = div9(int_digits) + div9(enc_byte[6:0]);

  // the sign bit of the first body byte is stored inverted
  assign first_byte = (phase == PH_FIRST);
  assign b_eff      = {enc_byte[7] ^ first_byte, enc_byte[6:0]};
  assign neg_cur    = first_byte ? !enc_byte[7] : is_negative;

  always_comb begin
    case (grp)
      GRP_LEAD:  grp_size = lead_bytes;
      GRP_WORDS: grp_size = 3'd4;
      GRP_TRAIL: grp_size = trail_bytes;
      default:   grp_size = 3'd0;
    endcase
  end

  always_comb begin
    if (bytes_left == '0) begin
      bl_cur  = grp_size;
      // sign-extend short groups from their first byte
      ws_base = (grp_size < 3'd4 && b_eff[7]) ? '1 : '0;
    end else begin
      bl_cur  = bytes_left;
      ws_base = word_shift;
    end
  end

  assign ws_new    = {ws_base[23:0], b_eff};
  assign bl_dec    = bl_cur - 1'b1;
  assign word_val  = ws_new ^ {32{neg_cur}};
  assign words_dec = (words_left != '0) ? words_left - 1'b1 : words_left;

  always_comb begin
    err_cur   = word_error;
    grp_after = GRP_DONE;
    case (grp)
      GRP_LEAD: begin
        grp_after = (words_left != '0) ? GRP_WORDS
                  : (trail_bytes != '0) ? GRP_TRAIL : GRP_DONE;
      end
      GRP_WORDS: begin
        err_cur   = word_error || (word_val >= 32'(WORD_BASE));
        grp_after = (words_dec != '0) ? GRP_WORDS
                  : (trail_bytes != '0) ? GRP_TRAIL : GRP_DONE;
      end
      default: grp_after = GRP_DONE;
    endcase
  end

  always_comb begin
    phase_next           = phase;
    grp_next             = grp;
    digits_total_next    = digits_total;
    digits_fraction_next = digits_fraction;
    lead_bytes_next      = lead_bytes;
    trail_bytes_next     = trail_bytes;
    trail_mod_next       = trail_mod;
    words_left_next      = words_left;
    bytes_left_next      = bytes_left;
    word_shift_next      = word_shift;
    is_negative_next     = is_negative;
    word_error_next      = word_error;
    first_grp_next       = first_grp;
    push                 = 1'b0;
    push_cmd.kind        = CMD_MAC;
    push_cmd.value       = word_val;
    push_cmd.mult        = WORD_BASE;
    push_cmd.first       = first_grp;
    push_cmd.last        = (grp_after == GRP_DONE);
    push_cmd.neg         = neg_cur;
    push_cmd.err         = err_cur;
    push_cmd.precision   = digits_total;
    push_cmd.scale       = digits_fraction;
    if (accept) begin
      case (phase)
        PH_PREC: begin
          digits_total_next = (enc_byte > 8'(MAX_PRECISION)) ? 7'(MAX_PRECISION + 1)
                                                             : enc_byte[6:0];
          phase_next = PH_SCALE;
        end
        PH_SCALE: begin
          if (bad_hdr) begin
            push               = 1'b1;
            push_cmd.kind      = CMD_BAD;
            push_cmd.last      = 1'b1;
            push_cmd.err       = 1'b0;
            push_cmd.precision = (digits_total > 7'(MAX_PRECISION)) ? 7'(MAX_PRECISION)
                                                                    : digits_total;
            push_cmd.scale     = (enc_byte > 8'(MAX_PRECISION)) ? 7'(MAX_PRECISION)
                                                                : enc_byte[6:0];
            phase_next         = PH_PREC;
          end else begin
            digits_fraction_next = enc_byte[6:0];
            lead_bytes_next      = hdr_lead;
            trail_bytes_next     = hdr_trail;
            trail_mod_next       = mod9(enc_byte[6:0]);
            words_left_next      = hdr_words;
            bytes_left_next      = '0;
            is_negative_next     = 1'b0;
            word_error_next      = 1'b0;
            first_grp_next       = 1'b1;
            grp_next             = (hdr_lead != '0) ? GRP_LEAD
                                 : (hdr_words != '0) ? GRP_WORDS
                                 : (hdr_trail != '0) ? GRP_TRAIL : GRP_DONE;
            phase_next           = PH_FIRST;
          end
        end
        default: begin
          if (bytes_left == '0 && grp_size == '0) begin
            // no group left to read: drop back to the header
            phase_next = PH_PREC;
          end else begin
            is_negative_next = neg_cur;
            phase_next       = PH_BODY;
            word_shift_next  = ws_new;
            bytes_left_next  = bl_dec;
            if (bl_dec == '0) begin
              push            = 1'b1;
              first_grp_next  = 1'b0;
              word_error_next = err_cur;
              grp_next        = grp_after;
              case (grp)
                GRP_LEAD:  push_cmd.kind = CMD_LEAD;
                GRP_WORDS: words_left_next = words_dec;
                default:   push_cmd.mult = POW10[trail_mod];
              endcase
              if (grp_after == GRP_DONE) begin
                phase_next = PH_PREC;
                grp_next   = GRP_LEAD;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_PREC;
      grp             <= GRP_LEAD;
      digits_total    <= '0;
      digits_fraction <= '0;
      words_left      <= '0;
      bytes_left      <= '0;
      is_negative     <= 1'b0;
      word_error      <= 1'b0;
      first_grp       <= 1'b0;
    end else begin
      phase           <= phase_next;
      grp             <= grp_next;
      digits_total    <= digits_total_next;
      digits_fraction <= digits_fraction_next;
      words_left      <= words_left_next;
      bytes_left      <= bytes_left_next;
      is_negative     <= is_negative_next;
      word_error      <= word_error_next;
      first_grp       <= first_grp_next;
    end
  end

  always_ff @(posedge clk) begin
    lead_bytes  <= lead_bytes_next;
    trail_bytes <= trail_bytes_next;
    trail_mod   <= trail_mod_next;
    word_shift  <= word_shift_next;
  end

endmodule
`default_nettype wire

// ===== design/bdd_back.sv =====
// Back end: multiply-accumulate over 64-bit chunks, sign fix-up and limb output.
`default_nettype none
module bdd_back (
  input  wire           clk,
  input  wire           rst,
  input  wire           head_valid,
  input  bdd_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  wire           out_stall,
  output logic [63:0]   limb,
  output logic [1:0]    limb_index,
  output logic          last_limb,
  output logic [6:0]    precision,
  output logic [6:0]    scale,
  output logic [1:0]    status
);
  import bdd_pkg::*;

  localparam logic [1:0] LAST_CHUNK = 2'(ACC_LIMBS - 1);
  localparam logic [1:0] LAST_LIMB  = 2'(RESULT_LIMBS - 1);

  back_state_t state, state_next;
  logic [1:0]  cnt, cnt_next;
  cmd_t        cur;
  logic [63:0] acc [ACC_LIMBS];
  logic [31:0] carry;
  logic        ecarry;

  logic        out_free, mac_done, emit_fire, emit_done, take;
  logic [63:0] a_chunk;
  logic [61:0] p0, p1;
  logic [63:0] t0, t1;
  logic [63:0] e_limb;
  logic        e_carry;

  assign out_free  = !out_valid || !out_stall;
  assign mac_done  = (state == BK_MAC) && (cnt == LAST_CHUNK);
  assign emit_fire = (state == BK_EMIT) && out_free;
  assign emit_done = emit_fire && (cur.kind == CMD_BAD || cnt == LAST_LIMB);
  assign take      = (state == BK_IDLE) || (mac_done && !cur.last) || emit_done;
  assign pop       = take && head_valid;

  // the first group of a value starts from zero
  assign a_chunk = cur.first ? '0 : acc[0];
  assign p0      = a_chunk[31:0] * cur.mult;
  assign p1      = a_chunk[63:32] * cur.mult;
  assign t0      = 64'(p0) + 64'(carry);
  assign t1      = 64'(p1) + 64'(t0[63:32]);

  assign {e_carry, e_limb} = 65'(acc[0] ^ {64{cur.neg}}) + 65'(ecarry);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      BK_MAC: begin
        cnt_next = cnt + 1'b1;
        if (mac_done) begin
          state_next = cur.last ? BK_EMIT : BK_IDLE;
          cnt_next   = '0;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          cnt_next = cnt + 1'b1;
        end
        if (emit_done) begin
          state_next = BK_IDLE;
          cnt_next   = '0;
        end
      end
      default: ;
    endcase
    if (pop) begin
      cnt_next = '0;
      case (head.kind)
        CMD_LEAD: state_next = head.last ? BK_EMIT : BK_IDLE;
        CMD_MAC:  state_next = BK_MAC;
        default:  state_next = BK_EMIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // acc rotates one chunk a cycle in BK_MAC and one per emitted limb: the chunk in use is always acc[0]
  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_LEAD) begin
      acc[0] <= {32'b0, head.value};
      for (int i = 1; i < ACC_LIMBS; i++) begin
        acc[i] <= '0;
      end
    end else if (state == BK_MAC || (emit_fire && cur.kind != CMD_BAD)) begin
      for (int i = 0; i < ACC_LIMBS - 1; i++) begin
        acc[i] <= acc[i+1];
      end
      acc[ACC_LIMBS-1] <= (state == BK_MAC) ? {t1[31:0], t0[31:0]} : acc[0];
    end
    if (pop) begin
      cur    <= head;
      carry  <= head.value;
      ecarry <= head.neg;
    end else begin
      if (state == BK_MAC) begin
        carry <= t1[63:32];
      end
      if (emit_fire && cur.kind != CMD_BAD) begin
        ecarry <= e_carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      precision <= cur.precision;
      scale     <= cur.scale;
      if (cur.kind == CMD_BAD) begin
        limb       <= '0;
        limb_index <= '0;
        last_limb  <= 1'b1;
        status     <= ST_HEADER;
      end else begin
        limb       <= e_limb;
        limb_index <= cnt;
        last_limb  <= (cnt == LAST_LIMB);
        status     <= cur.err ? ST_WORD : ST_OK;
      end
    end
  end

  a_limb_order: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_stall && !last_limb)
      |=> (!out_valid || limb_index == $past(limb_index) + 2'd1))
    else $error("limbs of one value out of order");
  a_bad_header_result: assert property (@(posedge clk) disable iff (rst)
      (out_valid && status == ST_HEADER) |-> (last_limb && limb_index == '0 && limb == '0))
    else $error("bad header result malformed");
  a_mac_kind: assert property (@(posedge clk) disable iff (rst)
      (state == BK_MAC) |-> (cur.kind == CMD_MAC))
    else $error("multiply step on a command that needs none");

endmodule
`default_nettype wire

// ===== design/binary_decimal_decoder.sv =====
// Top level of the binary decimal decoder: parser, command queue and back end.
// Takes one byte a cycle; stalls the input while the four-entry command queue is full.
// A full word's multiply-accumulate runs over every 64-bit chunk, two 32x30 products per chunk;
// limbs leave one a cycle while the output is not stalled. From the last byte of a word or
// trailing group, a value goes through the command queue, the multiply steps and the emit
// state to the output register; a leading group or a bad header skips the multiply steps.
// Synchronous reset returns the parser to the precision byte and empties the queue.
`default_nettype none
module binary_decimal_decoder (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  enc_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] limb,
  output logic [1:0]  limb_index,
  output logic        last_limb,
  output logic [6:0]  precision,
  output logic [6:0]  scale,
  output logic [1:0]  status
);
  import bdd_pkg::*;

  logic full, push, pop, head_valid;
  cmd_t push_cmd, head;

  assign in_stall = full;

  bdd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .enc_byte (enc_byte),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bdd_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  bdd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .limb       (limb),
    .limb_index (limb_index),
    .last_limb  (last_limb),
    .precision  (precision),
    .scale      (scale),
    .status     (status)
  );

endmodule
`default_nettype wire
